// ----- design/mer_pkg.sv -----
// shared types and constants for the microwire eeprom reader
package mer_pkg;

  localparam int unsigned WORD_COUNT = 64;
  localparam int unsigned ADDR_W     = 6;
  localparam int unsigned PHASE_W    = 6;

  // phase plan within one word
  localparam logic [PHASE_W-1:0] PH_CMD_FIRST  = 6'd2;
  localparam logic [PHASE_W-1:0] PH_CMD_LAST   = 6'd21;
  localparam logic [PHASE_W-1:0] PH_DATA_FIRST = 6'd23;
  localparam logic [PHASE_W-1:0] PH_DATA_LAST  = 6'd54;
  localparam logic [PHASE_W-1:0] PH_END        = 6'd55;

  // leading zero, start bit and read opcode 10 ahead of the address
  localparam logic [3:0] READ_PREFIX = 4'b0110;

  localparam logic [ADDR_W-1:0] FLOW_WORD_ADDR = 6'd6;
  localparam logic [ADDR_W-1:0] LAST_ADDR      = ADDR_W'(WORD_COUNT - 1);

  typedef struct packed {
    logic              start_read;
    logic              scan_all;
    logic [ADDR_W-1:0] word_address;
    logic              eeprom_data_pin;
  } mer_in_t;

  typedef struct packed {
    logic              program_enable;
    logic              chip_select;
    logic              shift_clock;
    logic              serial_data_out;
    logic              word_valid;
    logic [ADDR_W-1:0] word_index;
    logic [15:0]       word_value;
    logic [15:0]       word_sum;
    logic              scan_last;
    logic              flow_control_off;
    logic              busy_res;
  } mer_out_t;

endpackage

// ----- design/microwire_eeprom_reader.sv -----
// microwire eeprom read master, one pin update per item
//
//  channel | signals                       | direction | payload
//  --------+-------------------------------+-----------+------------------
//  input   | in_valid, in_ready, in_data   | in        | mer_pkg::mer_in_t
//  output  | out_valid, out_ready, out_data| out       | mer_pkg::mer_out_t
//
// one item per cycle unless the output stalls: each item is worked through
// in the cycle it is accepted, and its state update and pin levels are both
// registered at that edge, so the result is offered in the next cycle.
// a word read spans 56 items, a full scan 56 * WORD_COUNT items.
// reset returns the sequencer to idle and empties the output register.
// a stalled output register holds its item and stops input until taken.
module microwire_eeprom_reader (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mer_pkg::mer_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mer_pkg::mer_out_t out_data
);

  logic [mer_pkg::PHASE_W-1:0] tick_phase, tick_phase_next;
  logic [9:0]                  command_shift, command_shift_next;
  logic [15:0]                 data_shift, data_shift_next;
  logic [mer_pkg::ADDR_W-1:0]  current_address, current_address_next;
  logic                        scan_mode, scan_mode_next;
  logic                        active, active_next;
  logic [15:0]                 sum_register, sum_register_next;
  logic                        flow_flag, flow_flag_next;

  logic                        accept;
  logic                        start_go;
  logic                        run;
  logic [mer_pkg::PHASE_W-1:0] ph_cur;
  logic [mer_pkg::PHASE_W-1:0] ph;
  logic [9:0]                  cmd_cur;
  logic [15:0]                 data_cur;
  logic [mer_pkg::ADDR_W-1:0]  addr_cur;
  logic [mer_pkg::ADDR_W-1:0]  addr_start;
  logic [mer_pkg::ADDR_W-1:0]  addr_inc;
  logic                        scan_cur;
  logic [15:0]                 sum_cur;
  logic [15:0]                 sum_new;
  logic                        last;
  mer_pkg::mer_out_t           res;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign start_go   = !active && (in_data.start_read || in_data.scan_all);
  assign run        = active || start_go;
  assign addr_start = in_data.scan_all ? '0 : in_data.word_address;

  // values seen by this tick, with a fresh start already loaded
  assign ph_cur   = start_go ? '0 : tick_phase;
  assign cmd_cur  = start_go ? {mer_pkg::READ_PREFIX, addr_start} : command_shift;
  assign data_cur = start_go ? '0 : data_shift;
  assign addr_cur = start_go ? addr_start : current_address;
  assign scan_cur = start_go ? in_data.scan_all : scan_mode;
  assign sum_cur  = start_go ? '0 : sum_register;

  assign ph       = (ph_cur > mer_pkg::PH_END) ? mer_pkg::PH_END : ph_cur;
  assign sum_new  = sum_cur + data_cur;
  assign addr_inc = addr_cur + 1'b1;
  assign last     = !scan_cur || (addr_cur >= mer_pkg::LAST_ADDR);

  always_comb begin
    tick_phase_next      = ph_cur;
    command_shift_next   = cmd_cur;
    data_shift_next      = data_cur;
    current_address_next = addr_cur;
    scan_mode_next       = scan_cur;
    active_next          = active;
    sum_register_next    = sum_cur;
    flow_flag_next       = flow_flag;
    res                  = '0;

    if (run) begin
      res.busy_res       = 1'b1;
      res.program_enable = 1'b1;
      res.chip_select    = (ph <= mer_pkg::PH_DATA_LAST);

      if (ph >= mer_pkg::PH_CMD_FIRST && ph <= mer_pkg::PH_CMD_LAST) begin
        res.serial_data_out = cmd_cur[9];
        res.shift_clock     = ph[0];
        // move to the next command bit after its clock-high tick
        if (ph[0]) begin
          command_shift_next = {cmd_cur[8:0], 1'b0};
        end
      end else if (ph >= mer_pkg::PH_DATA_FIRST && ph <= mer_pkg::PH_DATA_LAST) begin
        if (ph[0]) begin
          res.shift_clock = 1'b1;
        end else begin
          data_shift_next = {data_cur[14:0], in_data.eeprom_data_pin};
        end
      end

      if (ph == mer_pkg::PH_END) begin
        res.word_valid    = 1'b1;
        res.word_index    = addr_cur;
        res.word_value    = data_cur;
        res.word_sum      = sum_new;
        res.scan_last     = last;
        sum_register_next = sum_new;
        if (scan_cur && addr_cur == mer_pkg::FLOW_WORD_ADDR) begin
          flow_flag_next = data_cur[1];
        end
        tick_phase_next = '0;
        if (last) begin
          active_next = 1'b0;
        end else begin
          active_next          = 1'b1;
          current_address_next = addr_inc;
          command_shift_next   = {mer_pkg::READ_PREFIX, addr_inc};
          data_shift_next      = '0;
        end
      end else begin
        active_next     = 1'b1;
        tick_phase_next = ph + 1'b1;
      end
    end

    res.flow_control_off = flow_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_phase      <= '0;
      command_shift   <= '0;
      data_shift      <= '0;
      current_address <= '0;
      scan_mode       <= 1'b0;
      active          <= 1'b0;
      sum_register    <= '0;
      flow_flag       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        tick_phase      <= tick_phase_next;
        command_shift   <= command_shift_next;
        data_shift      <= data_shift_next;
        current_address <= current_address_next;
        scan_mode       <= scan_mode_next;
        active          <= active_next;
        sum_register    <= sum_register_next;
        flow_flag       <= flow_flag_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for the microwire eeprom read master
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PIN_RANDOM    = 0;
  localparam int PIN_ONES      = 1;
  localparam int PIN_ZEROS     = 2;
  localparam int NO_FLOW_FORCE = -1;
  localparam int ROUND_ITEMS   = 433;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  mer_pkg::mer_in_t  in_data;
  logic              out_valid;
  logic              out_ready = 1'b0;
  mer_pkg::mer_out_t out_data;

  int send_pct;
  int recv_pct;
  int items_sent;
  int cycle_count = 0;

  microwire_eeprom_reader u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // tracks the read sequencer and queues the pin levels each tick should produce
  class eeprom_read_scoreboard;
    logic [mer_pkg::PHASE_W-1:0] phase;
    logic [9:0]                  command;
    logic [15:0]                 read_shift;
    logic [mer_pkg::ADDR_W-1:0]  address;
    logic [15:0]                 word_total;
    bit                          scanning;
    bit                          busy;
    bit                          flow_off;
    mer_pkg::mer_out_t           pin_levels_q[$];
    int                          errors;

    function new();
      phase      = '0;
      command    = '0;
      read_shift = '0;
      address    = '0;
      word_total = '0;
      scanning   = 1'b0;
      busy       = 1'b0;
      flow_off   = 1'b0;
      errors     = 0;
    endfunction

    function void load_word(logic [mer_pkg::ADDR_W-1:0] a);
      address    = a;
      command    = {mer_pkg::READ_PREFIX, a};
      read_shift = '0;
      phase      = '0;
    endfunction

    // true when the next tick samples the data pin; gives word and bit position
    function bit sample_bit(output int unsigned w, output int unsigned pos);
      logic [mer_pkg::PHASE_W-1:0] off;
      w   = address;
      pos = 0;
      if (!busy || phase < mer_pkg::PH_DATA_FIRST || phase > mer_pkg::PH_DATA_LAST)
        return 1'b0;
      off = phase - mer_pkg::PH_DATA_FIRST;
      if (!off[0]) return 1'b0;
      pos = 15 - ((off - 1) >> 1);
      return 1'b1;
    endfunction

    function void note_input(mer_pkg::mer_in_t it);
      mer_pkg::mer_out_t           r;
      logic [mer_pkg::PHASE_W-1:0] ph;
      logic [mer_pkg::PHASE_W-1:0] off;
      int unsigned                 k;
      r = '0;
      if (!busy && (it.start_read || it.scan_all)) begin
        scanning   = it.scan_all;
        busy       = 1'b1;
        word_total = '0;
        load_word(scanning ? '0 : it.word_address);
      end
      if (busy) begin
        r.busy_res       = 1'b1;
        r.program_enable = 1'b1;
        ph = (phase > mer_pkg::PH_END) ? mer_pkg::PH_END : phase;
        r.chip_select = (ph != mer_pkg::PH_END);
        if (ph >= mer_pkg::PH_CMD_FIRST && ph <= mer_pkg::PH_CMD_LAST) begin
          off = ph - mer_pkg::PH_CMD_FIRST;
          k = off >> 1;
          r.serial_data_out = command[9 - k];
          r.shift_clock     = off[0];
        end else if (ph >= mer_pkg::PH_DATA_FIRST && ph <= mer_pkg::PH_DATA_LAST) begin
          off = ph - mer_pkg::PH_DATA_FIRST;
          if (!off[0]) r.shift_clock = 1'b1;
          else read_shift = {read_shift[14:0], it.eeprom_data_pin};
        end
        if (ph == mer_pkg::PH_END) begin
          r.word_valid = 1'b1;
          r.word_index = address;
          r.word_value = read_shift;
          word_total   = word_total + read_shift;
          r.word_sum   = word_total;
          if (scanning && address == mer_pkg::FLOW_WORD_ADDR) flow_off = read_shift[1];
          r.scan_last = !scanning || address >= mer_pkg::LAST_ADDR;
          if (r.scan_last) begin
            busy  = 1'b0;
            phase = '0;
          end else begin
            load_word(address + 1'b1);
          end
        end else begin
          phase = ph + 1'b1;
        end
      end
      r.flow_control_off = flow_off;
      pin_levels_q.push_back(r);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(mer_pkg::mer_out_t got);
      mer_pkg::mer_out_t want;
      if (pin_levels_q.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
        return;
      end
      want = pin_levels_q.pop_front();
      compare("program_enable", want.program_enable, got.program_enable);
      compare("chip_select", want.chip_select, got.chip_select);
      compare("shift_clock", want.shift_clock, got.shift_clock);
      compare("serial_data_out", want.serial_data_out, got.serial_data_out);
      compare("word_valid", want.word_valid, got.word_valid);
      compare("word_index", want.word_index, got.word_index);
      compare("word_value", want.word_value, got.word_value);
      compare("word_sum", want.word_sum, got.word_sum);
      compare("scan_last", want.scan_last, got.scan_last);
      compare("flow_control_off", want.flow_control_off, got.flow_control_off);
      compare("busy_res", want.busy_res, got.busy_res);
    endfunction
  endclass

  eeprom_read_scoreboard sb;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver side: random stalls, check every taken item
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= ($urandom_range(99) >= recv_pct);
  end

  function automatic logic pick_pin(int mode, int flow_bit);
    int unsigned w;
    int unsigned pos;
    if (sb.sample_bit(w, pos) && w == mer_pkg::FLOW_WORD_ADDR && pos == 1 &&
        flow_bit != NO_FLOW_FORCE)
      return flow_bit[0];
    if (mode == PIN_ONES) return 1'b1;
    if (mode == PIN_ZEROS) return 1'b0;
    return 1'($urandom_range(1));
  endfunction

  task automatic send_tick(mer_pkg::mer_in_t it);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic run_idle_ticks(int n);
    mer_pkg::mer_in_t it;
    repeat (n) begin
      it.start_read      = 1'b0;
      it.scan_all        = 1'b0;
      it.word_address    = mer_pkg::ADDR_W'($urandom);
      it.eeprom_data_pin = 1'($urandom_range(1));
      send_tick(it);
    end
  endtask

  // one single read or scan, with ignored start requests sprinkled while busy
  task automatic run_sequence(bit do_scan, bit both, logic [mer_pkg::ADDR_W-1:0] a,
                              int pin_mode, int flow_bit);
    mer_pkg::mer_in_t it;
    it.start_read      = !do_scan || both;
    it.scan_all        = do_scan;
    it.word_address    = a;
    it.eeprom_data_pin = pick_pin(pin_mode, flow_bit);
    send_tick(it);
    while (sb.busy) begin
      it.start_read      = ($urandom_range(3) == 0);
      it.scan_all        = ($urandom_range(7) == 0);
      it.word_address    = mer_pkg::ADDR_W'($urandom);
      it.eeprom_data_pin = pick_pin(pin_mode, flow_bit);
      send_tick(it);
    end
  endtask

  initial begin
    int round_end;
    int pick;
    int pins;
    sb          = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    send_pct    = 28;
    recv_pct    = 72;
    items_sent  = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme addresses and pin levels, both starts at once, full scan
    run_idle_ticks(2);
    run_sequence(1'b0, 1'b0, mer_pkg::ADDR_W'(63), PIN_ONES, NO_FLOW_FORCE);
    run_sequence(1'b0, 1'b0, mer_pkg::ADDR_W'(0), PIN_ZEROS, NO_FLOW_FORCE);
    run_idle_ticks(1);
    run_sequence(1'b1, 1'b1, mer_pkg::ADDR_W'(5), PIN_RANDOM, 1);

    // single reads and idle ticks only, so the item count stays bounded
    for (int m = 0; m < 3; m++) begin
      send_pct  = (m == 0) ? 28 : (m == 1) ? 72 : 0;
      recv_pct  = (m == 0) ? 72 : (m == 1) ? 28 : 0;
      round_end = items_sent + ROUND_ITEMS;
      while (items_sent < round_end) begin
        pick = $urandom_range(99);
        if (pick < 20) begin
          run_idle_ticks($urandom_range(1, 6));
        end else begin
          case ($urandom_range(9))
            0: pins = PIN_ONES;
            1: pins = PIN_ZEROS;
            default: pins = PIN_RANDOM;
          endcase
          run_sequence(1'b0, 1'b0, mer_pkg::ADDR_W'($urandom), pins, NO_FLOW_FORCE);
        end
      end
    end
    in_valid <= 1'b0;

    while (sb.pin_levels_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
design/mer_pkg.sv
design/microwire_eeprom_reader.sv
sim/testbench.sv
